// ===== rtl/business_day_return_date_top_assert.svh =====
`ifndef BUSINESS_DAY_RETURN_DATE_TOP_ASSERT_SVH
`define BUSINESS_DAY_RETURN_DATE_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising clk edge outside reset
`define BDRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BDRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bdrd_pkg.sv =====
package bdrd_pkg;

  localparam int unsigned YEAR_MAX  = 9999;
  localparam int unsigned CENTURY   = 100;
  localparam int unsigned WEEK_DAYS = 7;
  localparam logic [6:0]  MASK_RESET = 7'd96;
  localparam logic [6:0]  MASK_ALL   = 7'h7f;

  typedef struct packed {
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [14:0] work_days;
  } req_t;

  typedef struct packed {
    logic [4:0]  ret_day;
    logic [3:0]  ret_month;
    logic [13:0] ret_year;
    logic [2:0]  ret_weekday;
    logic        bad_date;
  } rsp_t;

  // running date plus year remainders used for the leap test
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  wd;
    logic [6:0]  r100;
    logic [8:0]  r400;
  } date_t;

  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
    logic [4:0] dim;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: dim = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    dim = 5'd30;
      4'd2:                                       dim = leap ? 5'd29 : 5'd28;
      default:                                    dim = 5'd0;
    endcase
    return dim;
  endfunction

  // (31 * mm) / 12 with march-based month numbering
  function automatic logic [4:0] month_offset(input logic [3:0] month);
    logic [4:0] off;
    unique case (month)
      4'd1:    off = 5'd28;
      4'd2:    off = 5'd31;
      4'd3:    off = 5'd2;
      4'd4:    off = 5'd5;
      4'd5:    off = 5'd7;
      4'd6:    off = 5'd10;
      4'd7:    off = 5'd12;
      4'd8:    off = 5'd15;
      4'd9:    off = 5'd18;
      4'd10:   off = 5'd20;
      4'd11:   off = 5'd23;
      4'd12:   off = 5'd25;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

endpackage

// ===== rtl/bdrd_chan_if.sv =====
interface bdrd_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bdrd_sub_unit.sv =====
module bdrd_sub_unit (
  input  logic [14:0] acc,
  input  logic [6:0]  divisor,
  output logic        ge,
  output logic [14:0] diff
);

  assign ge   = acc >= {8'd0, divisor};
  assign diff = acc - {8'd0, divisor};

endmodule

// ===== rtl/bdrd_day_step.sv =====
module bdrd_day_step (
  input  bdrd_pkg::date_t cur,
  output bdrd_pkg::date_t nxt
);

  logic       leap;
  logic [4:0] dim;

  assign leap = (cur.year[1:0] == 2'd0 && cur.r100 != 7'd0) || cur.r400 == 9'd0;
  assign dim  = bdrd_pkg::days_in_month(cur.month, leap);

  always_comb begin
    nxt = cur;
    if (cur.day >= dim) begin
      nxt.day = 5'd1;
      if (cur.month >= 4'd12) begin
        nxt.month = 4'd1;
        nxt.year  = cur.year + 14'd1;
        nxt.r100  = (cur.r100 == 7'(bdrd_pkg::CENTURY - 1)) ? 7'd0 : cur.r100 + 7'd1;
        nxt.r400  = (cur.r400 == 9'(4 * bdrd_pkg::CENTURY - 1)) ? 9'd0 : cur.r400 + 9'd1;
      end else begin
        nxt.month = cur.month + 4'd1;
      end
    end else begin
      nxt.day = cur.day + 5'd1;
    end
    nxt.wd = (cur.wd == 3'(bdrd_pkg::WEEK_DAYS - 1)) ? 3'd0 : cur.wd + 3'd1;
  end

endmodule

// ===== rtl/business_day_return_date_top.sv =====
// business-day return date
// req channel: start_day, start_month, start_year, work_days; one item at a time.
// rsp channel: ret_day, ret_month, ret_year, ret_weekday, bad_date; one item per req.
// cfg channel: 7-bit weekend mask (bit i = weekday i, 0 = sunday, is off); always
//   ready; it must be written only while the block is idle, and the block itself does
//   not enforce this. reset value marks friday and saturday.
// the year divide and the weekday mod 7 run by repeated subtraction on one shared
//   compare/subtract unit; the walk then steps one calendar day per cycle.
// req.ready is low from acceptance until the result is handed to the output register.
// an invalid start date skips the weekday and the walk and is echoed with bad_date.
// results sit in a single output register; a stalled receiver holds it, and the block
//   then takes one more item and parks its finished result until the register frees.
// rst (synchronous, active high) empties the pipeline and restores the mask.
module business_day_return_date_top (
  input logic       clk,
  input logic       rst,
  bdrd_chan_if.sink   req,
  bdrd_chan_if.source rsp,
  bdrd_chan_if.sink   cfg
);

  `include "business_day_return_date_top_assert.svh"

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MOD7 = 5'b00100,
    S_WALK = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t          state;
  bdrd_pkg::date_t cur;
  bdrd_pkg::date_t step;
  logic [14:0]     n;
  logic [14:0]     acc;
  logic [7:0]      q;
  logic            bad;
  logic [6:0]      mask;
  logic            out_full;
  bdrd_pkg::rsp_t  out_data;

  logic [6:0]  divisor;
  logic        ge;
  logic [14:0] diff;

  // end-of-divide values
  logic        early;
  logic [6:0]  r100_fin;
  logic [8:0]  r400_fin;
  logic        leap_fin;
  logic [4:0]  dim_fin;
  logic        bad_fin;
  logic [13:0] yy;
  logic [7:0]  yy100;
  logic [5:0]  yy400;
  logic [14:0] wd_sum;
  logic        off;
  logic        take_out;
  logic        load_out;

  bdrd_sub_unit u_sub (
    .acc     (acc),
    .divisor (divisor),
    .ge      (ge),
    .diff    (diff)
  );

  bdrd_day_step u_step (
    .cur (cur),
    .nxt (step)
  );

  assign divisor = (state == S_DIV) ? 7'(bdrd_pkg::CENTURY) : 7'(bdrd_pkg::WEEK_DAYS);

  always_comb begin
    early    = cur.month <= 4'd2;
    r100_fin = acc[6:0];
    r400_fin = 9'(q[1:0]) * 9'(bdrd_pkg::CENTURY) + 9'(r100_fin);
    leap_fin = (cur.year[1:0] == 2'd0 && r100_fin != 7'd0) || r400_fin == 9'd0;
    dim_fin  = bdrd_pkg::days_in_month(cur.month, leap_fin);
    bad_fin  = cur.month < 4'd1 || cur.month > 4'd12 || cur.year < 14'd1 ||
               cur.year > 14'(bdrd_pkg::YEAR_MAX) || cur.day < 5'd1 || cur.day > dim_fin;
    yy       = cur.year - 14'(early);
    // march-based year: quotients drop by one when january/february sit on a boundary
    yy100    = q - 8'(early && r100_fin == 7'd0);
    yy400    = 6'(q >> 2) - 6'(early && r400_fin == 9'd0);
    wd_sum   = 15'(cur.day) + 15'(yy) + 15'(yy >> 2) + 15'(yy400) +
               15'(bdrd_pkg::month_offset(cur.month)) - 15'(yy100);
  end

  assign off      = mask[cur.wd];
  assign take_out = rsp.valid && rsp.ready;
  assign load_out = (state == S_DONE) && (!out_full || rsp.ready);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_full;
  assign rsp.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= bdrd_pkg::MASK_RESET;
    end else if (cfg.valid && cfg.ready) begin
      mask <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur.day   <= req.data.start_day;
            cur.month <= req.data.start_month;
            cur.year  <= req.data.start_year;
            cur.wd    <= 3'd0;
            n         <= req.data.work_days;
            acc       <= 15'(req.data.start_year);
            q         <= 8'd0;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (ge) begin
            acc <= diff;
            q   <= q + 8'd1;
          end else begin
            cur.r100 <= r100_fin;
            cur.r400 <= r400_fin;
            bad      <= bad_fin;
            acc      <= wd_sum;
            state    <= bad_fin ? S_DONE : S_MOD7;
          end
        end
        S_MOD7: begin
          if (ge) begin
            acc <= diff;
          end else begin
            cur.wd <= acc[2:0];
            state  <= (mask == bdrd_pkg::MASK_ALL) ? S_DONE : S_WALK;
          end
        end
        S_WALK: begin
          if (n != 15'd0) begin
            if (!off) begin
              n <= n - 15'd1;
            end
            cur <= step;
          end else if (off) begin
            cur <= step;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (load_out) begin
      out_full <= 1'b1;
    end else if (take_out) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.ret_day     <= cur.day;
      out_data.ret_month   <= cur.month;
      out_data.ret_year    <= cur.year;
      out_data.ret_weekday <= cur.wd;
      out_data.bad_date    <= bad;
    end
  end

  `BDRD_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state == S_DIV,
    "accepted item did not start the year divide")
  `BDRD_ASSERT_NOW(a_walk_date_sane, state == S_WALK,
    cur.day != 5'd0 && cur.month >= 4'd1 && cur.month <= 4'd12 && cur.wd != 3'd7,
    "walk reached an impossible date")
  `BDRD_ASSERT_NOW(a_rem_match, state == S_WALK,
    cur.r400 == 9'(cur.r100) || cur.r400 == 9'(cur.r100) + 9'd100 ||
    cur.r400 == 9'(cur.r100) + 9'd200 || cur.r400 == 9'(cur.r100) + 9'd300,
    "year remainders out of step")
  `BDRD_ASSERT_NEXT(a_count_down, state == S_WALK, n <= $past(n),
    "working day count grew during the walk")
  `BDRD_ASSERT_NOW(a_bad_no_walk, state == S_WALK, !bad,
    "invalid date entered the walk")

endmodule

// ===== dv/business_day_return_date_checker.sv =====
module business_day_return_date_checker
  import bdrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_ready,
  input  req_t       req_data,
  input  logic       rsp_valid,
  input  logic       rsp_ready,
  input  rsp_t       rsp_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [6:0] cfg_data,
  output int         errors,
  output int         outstanding
);

  logic [6:0] off_days = MASK_RESET;
  rsp_t       due_dates[$];
  int         fails = 0;

  assign errors = fails;

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    bit leap;
    leap = ((y % 4 == 0) && (y % CENTURY != 0)) || (y % 400 == 0);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic void advance(inout int unsigned d, inout int unsigned m,
                                  inout int unsigned y, inout int unsigned wd);
    if (d >= month_days(y, m)) begin
      d = 1;
      if (m >= 12) begin
        m = 1;
        y++;
      end else begin
        m++;
      end
    end else begin
      d++;
    end
    wd = (wd + 1) % WEEK_DAYS;
  endfunction

  function automatic rsp_t return_date(req_t r, logic [6:0] off);
    int unsigned d, m, y, n, wd, a, yy, mm;
    logic        bad;
    rsp_t        res;
    d  = r.start_day;
    m  = r.start_month;
    y  = r.start_year;
    n  = r.work_days;
    wd = 0;
    bad = (m < 1) || (m > 12) || (y < 1) || (y > YEAR_MAX) || (d < 1) ||
          (d > month_days(y, m));
    if (!bad) begin
      // march-based year for the weekday sum
      a  = (14 - m) / 12;
      yy = y - a;
      mm = m + 12 * a - 2;
      wd = (d + yy + yy / 4 - yy / CENTURY + yy / 400 + (31 * mm) / 12) % WEEK_DAYS;
      if (off != MASK_ALL) begin
        while (n != 0) begin
          if (!off[wd]) n--;
          advance(d, m, y, wd);
        end
        while (off[wd]) advance(d, m, y, wd);
      end
    end
    res.ret_day     = d[4:0];
    res.ret_month   = m[3:0];
    res.ret_year    = y[13:0];
    res.ret_weekday = wd[2:0];
    res.bad_date    = bad;
    return res;
  endfunction

  task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      fails++;
      $display("%0t %s: expected %0d, got %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      off_days <= MASK_RESET;
      due_dates.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_dates.size() == 0) begin
          fails++;
          $display("%0t unexpected result: expected none, got %h", $time, rsp_data);
        end else begin
          want = due_dates.pop_front();
          check_field("ret_day", want.ret_day, rsp_data.ret_day);
          check_field("ret_month", want.ret_month, rsp_data.ret_month);
          check_field("ret_year", want.ret_year, rsp_data.ret_year);
          check_field("ret_weekday", want.ret_weekday, rsp_data.ret_weekday);
          check_field("bad_date", want.bad_date, rsp_data.bad_date);
        end
      end
      if (req_valid && req_ready) due_dates.push_back(return_date(req_data, off_days));
      if (cfg_valid && cfg_ready) off_days <= cfg_data;
    end
    outstanding <= due_dates.size();
  end

endmodule

// ===== dv/business_day_return_date_top_tb.sv =====
module business_day_return_date_top_tb;
  import bdrd_pkg::*;

  localparam int LIMIT     = 6_000_000;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bdrd_chan_if #(.data_t(req_t))       req_if ();
  bdrd_chan_if #(.data_t(rsp_t))       rsp_if ();
  bdrd_chan_if #(.data_t(logic [6:0])) cfg_if ();

  logic       req_valid = 1'b0;
  req_t       req_item = '0;
  logic       rsp_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [6:0] cfg_data = '0;
  logic       quiet = 1'b0;
  logic       hold_token = 1'b0;
  logic       hold_seen = 1'b0;
  int         rsp_wait = 0;
  int         rsp_stall;
  int         cycles = 0;
  int         errors;
  int         outstanding;

  assign req_if.valid = req_valid;
  assign req_if.data  = req_item;
  assign rsp_if.ready = rsp_ready;
  assign cfg_if.valid = cfg_valid;
  assign cfg_if.data  = cfg_data;

  business_day_return_date_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  business_day_return_date_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_if.valid),
    .req_ready   (req_if.ready),
    .req_data    (req_if.data),
    .rsp_valid   (rsp_if.valid),
    .rsp_ready   (rsp_if.ready),
    .rsp_data    (rsp_if.data),
    .cfg_valid   (cfg_if.valid),
    .cfg_ready   (cfg_if.ready),
    .cfg_data    (cfg_if.data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: short random stall after each item, long hold when the token flips
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_wait  <= 0;
      hold_seen <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      rsp_ready <= 1'b0;
      rsp_wait  <= LONG_HOLD;
    end else if (rsp_wait > 0) begin
      rsp_wait  <= rsp_wait - 1;
      rsp_ready <= (rsp_wait == 1);
    end else if (rsp_ready && rsp_if.valid) begin
      rsp_stall = quiet ? 0 : $urandom_range(0, 5);
      rsp_ready <= (rsp_stall == 0);
      rsp_wait  <= rsp_stall;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  function automatic req_t make_req(int unsigned d, int unsigned m, int unsigned y,
                                    int unsigned n);
    req_t r;
    r.start_day   = 5'(d);
    r.start_month = 4'(m);
    r.start_year  = 14'(y);
    r.work_days   = 15'(n);
    return r;
  endfunction

  function automatic req_t random_req();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // raw field noise, mostly invalid dates
      r.start_day   = 5'($urandom);
      r.start_month = 4'($urandom);
      r.start_year  = 14'($urandom);
    end else begin
      r.start_day   = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(29, 31))
                                                  : 5'($urandom_range(1, 28));
      r.start_month = 4'($urandom_range(1, 12));
      r.start_year  = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(1, 400))
                                                  : 14'($urandom_range(1, YEAR_MAX));
    end
    pick = $urandom_range(0, 99);
    if (pick < 80)      r.work_days = 15'($urandom_range(0, 40));
    else if (pick < 97) r.work_days = 15'($urandom_range(0, 1000));
    else                r.work_days = 15'($urandom_range(0, 3000));
    return r;
  endfunction

  task automatic send_req(input req_t item);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= item;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_mask(input logic [6:0] mask);
    cfg_valid <= 1'b1;
    cfg_data  <= mask;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [6:0] masks[4];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset weekend: friday and saturday
    send_req(make_req(1, 1, 1, 0));
    send_req(make_req(31, 12, 9999, 32767));
    send_req(make_req(29, 2, 2000, 10));
    send_req(make_req(29, 2, 1900, 4));
    send_req(make_req(29, 2, 2024, 3));
    send_req(make_req(28, 2, 2100, 1));
    send_req(make_req(0, 5, 2020, 7));
    send_req(make_req(10, 0, 2020, 2));
    send_req(make_req(10, 13, 2020, 2));
    send_req(make_req(31, 15, 16383, 32767));
    send_req(make_req(1, 1, 0, 5));
    send_req(make_req(1, 1, 10000, 5));
    send_req(make_req(31, 4, 2021, 3));
    // starts on a friday with nothing to consume
    send_req(make_req(1, 3, 2024, 0));
    send_req(make_req(30, 12, 2023, 5));
    wait_idle();

    // no working day at all
    write_mask(MASK_ALL);
    send_req(make_req(15, 6, 2023, 100));
    send_req(make_req(31, 2, 2023, 1));
    wait_idle();

    write_mask(7'h00);
    send_req(make_req(31, 12, 1999, 1));
    send_req(make_req(28, 2, 2023, 0));
    wait_idle();

    // only sundays count, pushes the year past the input range
    write_mask(7'h7e);
    send_req(make_req(31, 12, 9999, 12000));
    send_req(make_req(1, 1, 1, 1));
    wait_idle();

    write_mask(7'h01);
    send_req(make_req(7, 7, 777, 31));
    wait_idle();

    // receiver holds off while short items keep coming
    hold_token <= ~hold_token;
    repeat (6) send_req(make_req($urandom_range(1, 28), $urandom_range(1, 12),
                                 $urandom_range(1, 50), $urandom_range(0, 5)));
    wait_idle();

    masks[0] = 7'h41;
    masks[1] = 7'($urandom_range(0, 127));
    masks[2] = 7'($urandom_range(0, 127));
    masks[3] = 7'h7e;
    for (int p = 0; p < 4; p++) begin
      write_mask(masks[p]);
      quiet <= (p == 2);
      repeat (25) send_req(random_req());
      wait_idle();
    end
    quiet <= 1'b0;

    repeat (50) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bdrd_pkg.sv
rtl/bdrd_chan_if.sv
rtl/bdrd_sub_unit.sv
rtl/bdrd_day_step.sv
rtl/business_day_return_date_top.sv
dv/business_day_return_date_checker.sv
dv/business_day_return_date_top_tb.sv
